### rtl/core/pcrct_pkg.sv
// shared types and constants for the per-client read counter table
// no dependencies; imported by pcrct_dp, pcrct_ctrl and the top module
`default_nettype none

package pcrct_pkg;

    localparam int ACTION_W   = 3;
    localparam int CLIENT_W   = 16;
    localparam int STATUS_W   = 2;
    localparam int RCOUNT_W   = 16;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 24;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT  = 3'd0,
        ACT_INC_ALL = 3'd1,
        ACT_DEC     = 3'd2,
        ACT_REMOVE  = 3'd3,
        ACT_GET     = 3'd4
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture request, clear walk index and result
        logic rd;         // read entry at walk index
        logic rd_next;    // read entry one above walk index
        logic wr_ins;     // append new client with zero count
        logic wr_inc;     // write back entry with saturating increment
        logic wr_dec;     // write back entry with saturating decrement
        logic wr_shift;   // move read entry down to walk index
        logic idx_inc;
        logic occ_dec;
        logic set_nf;
        logic set_full;
        logic cap_count;
        logic out_load;   // hand result to output register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        action_t act;
        logic    walk_done;   // walk index reached occupancy
        logic    full;
        logic    match;       // read entry holds the requested client
        logic    last_shift;  // no entry above walk index
        logic    out_busy;
    } sts_t;

endpackage

`default_nettype wire

### rtl/core/pcrct_ram.sv
// generic single-port-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module pcrct_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/core/pcrct_dp.sv
// datapath: request registers, entry ram, occupancy, walk index, result register
// depends on pcrct_pkg and pcrct_ram
`default_nettype none

module pcrct_dp
    import pcrct_pkg::*;
#(
    parameter int MAX_CLIENTS = 16,
    parameter int COUNT_BITS  = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire cmd_t                 cmd,
    output sts_t                      sts,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata
);

    localparam int IDX_W   = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
    localparam int OCC_W   = $clog2(MAX_CLIENTS + 1);
    localparam int ENTRY_W = CLIENT_W + COUNT_BITS;

    action_t               act_reg;
    logic [CLIENT_W-1:0]   id_reg;
    logic [OCC_W-1:0]      occ_reg, occ_next;
    logic [OCC_W-1:0]      idx_reg, idx_next;
    logic [OCC_W-1:0]      idx_p1;
    status_t               res_status_reg;
    logic [RCOUNT_W-1:0]   res_count_reg;
    logic                  m_tvalid_reg;
    status_t               m_status_reg;
    logic [RCOUNT_W-1:0]   m_count_reg;

    logic                  ram_we, ram_re;
    logic [IDX_W-1:0]      ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0]    ram_wdata, ram_rdata;
    logic [CLIENT_W-1:0]   rd_client;
    logic [COUNT_BITS-1:0] rd_count, cnt_inc, cnt_dec;
    logic [RCOUNT_W-1:0]   cnt_clamp;

    assign idx_p1    = idx_reg + OCC_W'(1);
    assign rd_client = ram_rdata[ENTRY_W-1:COUNT_BITS];
    assign rd_count  = ram_rdata[COUNT_BITS-1:0];
    assign cnt_inc   = (rd_count == '1) ? rd_count : rd_count + COUNT_BITS'(1);
    assign cnt_dec   = (rd_count == '0) ? rd_count : rd_count - COUNT_BITS'(1);

    generate
        if (COUNT_BITS > RCOUNT_W) begin : g_clamp
            assign cnt_clamp = (|rd_count[COUNT_BITS-1:RCOUNT_W]) ? '1
                                                                 : rd_count[RCOUNT_W-1:0];
        end else if (COUNT_BITS == RCOUNT_W) begin : g_same
            assign cnt_clamp = rd_count;
        end else begin : g_ext
            assign cnt_clamp = {{(RCOUNT_W-COUNT_BITS){1'b0}}, rd_count};
        end
    endgenerate

    // ram port steering
    always_comb begin
        ram_we    = cmd.wr_ins | cmd.wr_inc | cmd.wr_dec | cmd.wr_shift;
        ram_re    = cmd.rd | cmd.rd_next;
        ram_raddr = cmd.rd_next ? idx_p1[IDX_W-1:0] : idx_reg[IDX_W-1:0];
        ram_waddr = idx_reg[IDX_W-1:0];
        ram_wdata = ram_rdata;
        if (cmd.wr_ins) begin
            ram_waddr = occ_reg[IDX_W-1:0];
            ram_wdata = {id_reg, {COUNT_BITS{1'b0}}};
        end else if (cmd.wr_inc) begin
            ram_wdata = {rd_client, cnt_inc};
        end else if (cmd.wr_dec) begin
            ram_wdata = {rd_client, cnt_dec};
        end
    end

    pcrct_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_CLIENTS)
    ) u_entry_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        occ_next = occ_reg;
        if (cmd.wr_ins) begin
            occ_next = occ_reg + OCC_W'(1);
        end else if (cmd.occ_dec) begin
            occ_next = occ_reg - OCC_W'(1);
        end
        idx_next = idx_reg;
        if (cmd.load) begin
            idx_next = '0;
        end else if (cmd.idx_inc || cmd.wr_shift) begin
            idx_next = idx_p1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg      <= '0;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            occ_reg <= occ_next;
            idx_reg <= idx_next;
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            act_reg        <= action_t'(s_tdata[ACTION_W-1:0]);
            id_reg         <= s_tdata[ACTION_W +: CLIENT_W];
            res_status_reg <= ST_OK;
            res_count_reg  <= '0;
        end else begin
            if (cmd.set_nf) begin
                res_status_reg <= ST_NOT_FOUND;
            end else if (cmd.set_full) begin
                res_status_reg <= ST_FULL;
            end
            if (cmd.cap_count) begin
                res_count_reg <= cnt_clamp;
            end
        end
        if (cmd.out_load) begin
            m_status_reg <= res_status_reg;
            m_count_reg  <= res_count_reg;
        end
    end

    always_comb begin
        sts.act        = act_reg;
        sts.walk_done  = (idx_reg == occ_reg);
        sts.full       = (occ_reg == OCC_W'(MAX_CLIENTS));
        sts.match      = (rd_client == id_reg);
        sts.last_shift = (idx_p1 >= occ_reg);
        sts.out_busy   = m_tvalid_reg & ~m_tready;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W-STATUS_W-RCOUNT_W){1'b0}}, m_count_reg, m_status_reg};

endmodule

`default_nettype wire

### rtl/core/pcrct_ctrl.sv
// controller state machine: sequences search, update and gap closing
// depends on pcrct_pkg
`default_nettype none

module pcrct_ctrl
    import pcrct_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic      s_tready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_DECIDE   = 6'b000010,
        S_CHECK    = 6'b000100,
        S_SHIFT    = 6'b001000,
        S_SHIFT_WR = 6'b010000,
        S_RESP     = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                state_next = S_RESP;
                case (sts.act)
                    ACT_INSERT: begin
                        if (sts.full) begin
                            cmd.set_full = 1'b1;
                        end else begin
                            cmd.wr_ins = 1'b1;
                        end
                    end
                    ACT_INC_ALL, ACT_DEC, ACT_REMOVE, ACT_GET: begin
                        if (sts.walk_done) begin
                            cmd.set_nf = (sts.act != ACT_INC_ALL);
                        end else begin
                            cmd.rd     = 1'b1;
                            state_next = S_CHECK;
                        end
                    end
                    default: ;
                endcase
            end
            S_CHECK: begin
                state_next = S_DECIDE;
                if (sts.act == ACT_INC_ALL) begin
                    cmd.wr_inc  = 1'b1;
                    cmd.idx_inc = 1'b1;
                end else if (!sts.match) begin
                    cmd.idx_inc = 1'b1;
                end else if (sts.act == ACT_DEC) begin
                    cmd.wr_dec = 1'b1;
                    state_next = S_RESP;
                end else if (sts.act == ACT_GET) begin
                    cmd.cap_count = 1'b1;
                    state_next    = S_RESP;
                end else begin
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (sts.last_shift) begin
                    cmd.occ_dec = 1'b1;
                    state_next  = S_RESP;
                end else begin
                    cmd.rd_next = 1'b1;
                    state_next  = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                cmd.wr_shift = 1'b1;
                state_next   = S_SHIFT;
            end
            S_RESP: begin
                if (!sts.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/per_client_read_counter_table.sv
// Per-client pending-read counter table. Each input transaction carries an
// action (insert, increment all, decrement, remove, get reads) and a client id,
// and yields exactly one result transaction with a status and a read count.
// Clients live in insertion order in an entry ram with one write and one
// registered read port; the occupancy count marks the valid entries, so no
// clearing pass runs after reset. Each entry visit reads the entry and then
// acts on it. Insert appends at the occupancy; increment all and any lookup
// that misses visit every valid entry; decrement and get reads stop at the
// oldest match, and remove also moves every later entry down one place. A
// result waits to be loaded while the previous one is held in the output
// register by backpressure. A new request is taken while the previous result
// still waits in the output register.
// depends on pcrct_pkg, pcrct_ctrl, pcrct_dp
`default_nettype none

module per_client_read_counter_table
    import pcrct_pkg::*;
#(
    parameter int MAX_CLIENTS = 16,
    parameter int COUNT_BITS  = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // action [2:0], client_id [18:3]
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata    // status [1:0], read_count [17:2]
);

    cmd_t cmd;
    sts_t sts;

    pcrct_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pcrct_dp #(
        .MAX_CLIENTS (MAX_CLIENTS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire
